/* src/msi_vector_region_allocator_core_macros.svh */
// assertion macros shared by the allocator rtl
`ifndef MSI_VECTOR_REGION_ALLOCATOR_CORE_MACROS_SVH
`define MSI_VECTOR_REGION_ALLOCATOR_CORE_MACROS_SVH

// checked only while out of reset
`define MSIVRA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// checked at every edge, reset included
`define MSIVRA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/msivra_pkg.sv */
// shared types, constants and helpers of the msi vector region allocator
package msivra_pkg;

	localparam int DEF_MAX_VECTORS = 512;
	localparam int WORD_W          = 32;
	localparam int WORD_SH         = 5;
	localparam int CNT_W           = 10;
	localparam int VEC_W           = 9;
	localparam int K_W             = 4;
	localparam int VC_RESET        = 512;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FULL = 1'b1;

	typedef struct packed {
		logic             op;
		logic [CNT_W-1:0] count;
		logic [VEC_W-1:0] start;
	} req_t;

	typedef struct packed {
		logic             valid;
		logic             status;
		logic [VEC_W-1:0] grant;
	} res_t;

	// log2 of the count rounded up to a power of two; 0 and 1 give 0
	function automatic logic [K_W-1:0] pow2_k(input logic [CNT_W-1:0] n);
		logic [K_W-1:0] k;
		k = K_W'(CNT_W);
		for (int i = CNT_W; i >= 0; i--) begin
			if (((CNT_W+1)'(1) << i) >= {1'b0, n}) begin
				k = K_W'(i);
			end
		end
		return k;
	endfunction

endpackage

/* src/msivra_bitmap.sv */
// occupancy bitmap word memory with per-word valid bits cleared at reset
module msivra_bitmap #(
	parameter int MAX_VECTORS = msivra_pkg::DEF_MAX_VECTORS,
	localparam int WORDS = (MAX_VECTORS + msivra_pkg::WORD_W - 1) / msivra_pkg::WORD_W,
	localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [WA_W-1:0]               rd_addr,
	output logic [msivra_pkg::WORD_W-1:0] rd_data,
	input  logic                          wr_en,
	input  logic [WA_W-1:0]               wr_addr,
	input  logic [msivra_pkg::WORD_W-1:0] wr_data
);
	import msivra_pkg::*;

	logic [WORD_W-1:0] mem_q [WORDS];
	logic [WORD_W-1:0] rdata_q;
	logic [WORDS-1:0]  vld_q;
	logic              rvld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	// a word never written reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rvld_q ? rdata_q : '0;

endmodule

/* src/msivra_ctrl.sv */
// scan and update sequencer: word-wise read, evaluate, write back
`include "msi_vector_region_allocator_core_macros.svh"

module msivra_ctrl #(
	parameter int MAX_VECTORS = msivra_pkg::DEF_MAX_VECTORS,
	localparam int WORDS = (MAX_VECTORS + msivra_pkg::WORD_W - 1) / msivra_pkg::WORD_W,
	localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  msivra_pkg::req_t              req,
	output logic                          ready,
	input  logic [msivra_pkg::CNT_W-1:0]  bound,
	output msivra_pkg::res_t              res,
	input  logic                          res_ready,
	output logic                          rd_en,
	output logic [WA_W-1:0]               rd_addr,
	input  logic [msivra_pkg::WORD_W-1:0] rd_data,
	output logic                          wr_en,
	output logic [WA_W-1:0]               wr_addr,
	output logic [msivra_pkg::WORD_W-1:0] wr_data
);
	import msivra_pkg::*;

	localparam int WC_W  = $clog2(WORDS + 33);
	localparam int POS_W = WC_W + WORD_SH + 1;
	localparam int KS_W  = $clog2(WORD_SH + 1);
	localparam int SS_W  = WORD_SH + 1;
	localparam int IX_W  = WORD_SH;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_EV   = 3'd2;
	localparam logic [2:0] ST_WR   = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

	logic [2:0]       state_q, state_d;
	logic             op_q;
	logic [K_W-1:0]   k_q;
	logic [VEC_W-1:0] start_q;
	logic [WC_W-1:0]  w_q, w_d, rs_q, rs_d, n_q, n_d;
	logic             status_q, status_d;
	logic [VEC_W-1:0] grant_q, grant_d;

	logic              wide_req;
	logic [KS_W-1:0]   ks;
	logic [SS_W-1:0]   s_small;
	logic [WORD_W-1:0] smask;
	logic [POS_W-1:0]  s_ext, wbase, rsbase, bnd_ext, start_p, hi, end_p, rem;
	logic [WC_W-1:0]   nw;
	logic [WORD_W-1:0] usable, occ, cand, setm, clr, amask;
	logic              found;
	logic [IX_W-1:0]   idx, lo_off, hi_off;

	assign wide_req = k_q > K_W'(WORD_SH);
	assign ks       = wide_req ? KS_W'(WORD_SH) : k_q[KS_W-1:0];
	assign s_small  = SS_W'(1) << ks;
	assign smask    = ONES >> (SS_W'(WORD_W) - s_small);
	// alignment mask for the group size
	assign amask    = WORD_W'(s_small - SS_W'(1));
	assign s_ext    = POS_W'(1) << k_q;
	assign nw       = WC_W'(s_ext >> WORD_SH);
	assign wbase    = POS_W'(w_q) << WORD_SH;
	assign rsbase   = POS_W'(rs_q) << WORD_SH;
	assign bnd_ext  = POS_W'(bound);
	assign start_p  = POS_W'(start_q);
	assign hi       = start_p + s_ext - POS_W'(1);
	assign end_p    = ((hi >> WORD_SH) > POS_W'(WORDS - 1)) ? POS_W'(WORDS - 1)
	                                                        : (hi >> WORD_SH);

	// bits at or above the placement bound count as taken
	assign rem    = bnd_ext - wbase;
	assign usable = (rem >= POS_W'(WORD_W)) ? ONES : ~(ONES << rem[IX_W-1:0]);
	assign occ    = rd_data | ~usable;

	// aligned free groups inside one word, lowest first
	always_comb begin
		cand  = '0;
		found = 1'b0;
		idx   = '0;
		for (int i = 0; i < WORD_W; i++) begin
			cand[i] = ((WORD_W'(i) & amask) == '0) && (((occ >> i) & smask) == '0);
		end
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (cand[i]) begin
				found = 1'b1;
				idx   = IX_W'(i);
			end
		end
	end

	assign setm = smask << idx;

	// free: bits of the region that fall into the current word
	assign lo_off = (start_p <= wbase) ? '0 : IX_W'(start_p - wbase);
	assign hi_off = (hi >= wbase + POS_W'(WORD_W - 1)) ? IX_W'(WORD_W - 1)
	                                                   : IX_W'(hi - wbase);
	assign clr    = (ONES << lo_off) & (ONES >> (IX_W'(WORD_W - 1) - hi_off));

	always_comb begin
		state_d  = state_q;
		w_d      = w_q;
		rs_d     = rs_q;
		n_d      = n_q;
		status_d = status_q;
		grant_d  = grant_q;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		wr_data  = rd_data;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_RD;
					w_d     = (req.op == OP_FREE) ? WC_W'(req.start >> WORD_SH) : '0;
					rs_d    = '0;
					n_d     = '0;
				end
			end
			ST_RD: begin
				if (op_q == OP_FREE) begin
					if (POS_W'(w_q) > end_p) begin
						state_d  = ST_DONE;
						status_d = ST_OK;
						grant_d  = start_q;
					end else begin
						rd_en   = 1'b1;
						state_d = ST_EV;
					end
				end else if (!wide_req) begin
					if (wbase >= bnd_ext) begin
						state_d  = ST_DONE;
						status_d = ST_FULL;
						grant_d  = '0;
					end else begin
						rd_en   = 1'b1;
						state_d = ST_EV;
					end
				end else begin
					if (n_q == '0 && rsbase + s_ext > bnd_ext) begin
						state_d  = ST_DONE;
						status_d = ST_FULL;
						grant_d  = '0;
					end else begin
						rd_en   = 1'b1;
						state_d = ST_EV;
					end
				end
			end
			ST_EV: begin
				if (op_q == OP_FREE) begin
					wr_en   = 1'b1;
					wr_data = rd_data & ~clr;
					w_d     = w_q + WC_W'(1);
					state_d = ST_RD;
				end else if (!wide_req) begin
					if (found) begin
						wr_en    = 1'b1;
						wr_data  = rd_data | setm;
						status_d = ST_OK;
						grant_d  = VEC_W'(wbase + POS_W'(idx));
						state_d  = ST_DONE;
					end else begin
						w_d     = w_q + WC_W'(1);
						state_d = ST_RD;
					end
				end else begin
					if (rd_data == '0) begin
						if (n_q == nw - WC_W'(1)) begin
							n_d     = '0;
							w_d     = rs_q;
							state_d = ST_WR;
						end else begin
							n_d     = n_q + WC_W'(1);
							w_d     = w_q + WC_W'(1);
							state_d = ST_RD;
						end
					end else begin
						rs_d    = rs_q + nw;
						w_d     = rs_q + nw;
						n_d     = '0;
						state_d = ST_RD;
					end
				end
			end
			ST_WR: begin
				wr_en   = 1'b1;
				wr_data = ONES;
				if (n_q == nw - WC_W'(1)) begin
					status_d = ST_OK;
					grant_d  = VEC_W'(rsbase);
					state_d  = ST_DONE;
				end else begin
					n_d = n_q + WC_W'(1);
					w_d = w_q + WC_W'(1);
				end
			end
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rd_addr = w_q[WA_W-1:0];
	assign wr_addr = w_q[WA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			w_q     <= '0;
			rs_q    <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			w_q     <= w_d;
			rs_q    <= rs_d;
			n_q     <= n_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			op_q    <= req.op;
			k_q     <= pow2_k(req.count);
			start_q <= req.start;
		end
		status_q <= status_d;
		grant_q  <= grant_d;
	end

	assign ready      = state_q == ST_IDLE;
	assign res.valid  = state_q == ST_DONE;
	assign res.status = status_q;
	assign res.grant  = grant_q;

	`MSIVRA_ASSERT(a_no_rd_wr_same_cycle, !(rd_en && wr_en), "read and write in one cycle")
	`MSIVRA_ASSERT(a_rd_then_eval, rd_en |=> state_q == ST_EV, "read not followed by evaluate")
	`MSIVRA_ASSERT(a_fail_grant_zero, res.valid && res.status == ST_FULL |-> res.grant == '0, "failed allocate with nonzero start")

endmodule

/* src/msi_vector_region_allocator_core.sv */
// top level of the msi vector region allocator: stream ports, register, output stage
// Allocates and frees power-of-two blocks of interrupt vectors held in an occupancy
// bitmap of MAX_VECTORS bits, stored as 32-bit words in a single-port-style memory
// with a registered read. One request is worked at a time; s_tready is high
// only while the sequencer is idle, and a finished result sits in an output register
// so the next request can start while it waits. Every bitmap word visited is read,
// then evaluated, and written back where it changes. Allocate of up to 32 vectors
// scans words until a fit. Larger allocate checks the words of each aligned region,
// then writes every word of the granted region. Free visits every word the region
// touches, and an unaligned start touches one more word. The bitmap needs no
// clearing pass: every word has a valid bit cleared by reset and an unwritten word
// reads as all free. vector_count may be written only while idle.
`include "msi_vector_region_allocator_core_macros.svh"

module msi_vector_region_allocator_core #(
	parameter int MAX_VECTORS = msivra_pkg::DEF_MAX_VECTORS
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // region_count [9:0], start_vector [18:10], zero pad
	input  logic [0:0]  s_tuser,   // opcode [0]
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // granted_vector [8:0], zero pad
	output logic [0:0]  m_tuser,   // status [0]
	// vector_count register
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata
);
	import msivra_pkg::*;

	localparam int WORDS = (MAX_VECTORS + WORD_W - 1) / WORD_W;
	localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CMAX  = (1 << CNT_W) - 1;

	// placement bound never exceeds the bitmap size
	localparam logic [CNT_W-1:0] MAX_CLIP = CNT_W'((MAX_VECTORS > CMAX) ? CMAX : MAX_VECTORS);

	logic [CNT_W-1:0]  vcount_q;
	logic [CNT_W-1:0]  bound;
	req_t              req;
	res_t              res;
	logic              res_ready;
	logic              ctrl_ready;
	logic              rd_en, wr_en;
	logic [WA_W-1:0]   rd_addr, wr_addr;
	logic [WORD_W-1:0] rd_data, wr_data;
	logic              out_valid_q;
	logic              out_status_q;
	logic [VEC_W-1:0]  out_grant_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= CNT_W'(VC_RESET);
		end else if (cfg_we) begin
			vcount_q <= cfg_wdata;
		end
	end

	assign bound = (vcount_q > MAX_CLIP) ? MAX_CLIP : vcount_q;

	// unpack the request
	assign req.op    = s_tuser[0];
	assign req.count = s_tdata[CNT_W-1:0];
	assign req.start = s_tdata[CNT_W+VEC_W-1:CNT_W];

	assign s_tready = ctrl_ready;

	msivra_ctrl #(
		.MAX_VECTORS (MAX_VECTORS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req       (req),
		.ready     (ctrl_ready),
		.bound     (bound),
		.res       (res),
		.res_ready (res_ready),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	msivra_bitmap #(
		.MAX_VECTORS (MAX_VECTORS)
	) u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// output register: loads when empty or being drained
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			out_status_q <= res.status;
			out_grant_q  <= res.grant;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tuser[0] = out_status_q;
	assign m_tdata    = {{(16 - VEC_W){1'b0}}, out_grant_q};

	`MSIVRA_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "request taken while busy")
	`MSIVRA_ASSERT(a_result_lands, res.valid && res_ready |=> m_tvalid, "result lost before output")
	`MSIVRA_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !m_tvalid, "output valid during reset")

endmodule

/* verif/testbench.sv */
// self-checking testbench for the msi vector region allocator core
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import msivra_pkg::*;

	localparam int NUM_VECTORS = DEF_MAX_VECTORS;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_MAX  = 10;
	localparam int IDLE_PCT    = 38;
	localparam int HOLD_CYCLES = 500;

	// one result as the block reports it
	typedef struct packed {
		logic             status;
		logic [VEC_W-1:0] grant;
	} outcome_t;

	// occupancy bitmap mirror and the queue of results still owed by the block
	class vector_bitmap_board;
		bit [NUM_VECTORS-1:0] in_use;
		logic [CNT_W-1:0]     vector_count;
		outcome_t             grants_due[$];
		int                   mismatches;

		function new();
			in_use       = '0;
			vector_count = CNT_W'(VC_RESET);
			mismatches   = 0;
		endfunction

		// apply one accepted request to the bitmap and queue its result
		function outcome_t book_request(input logic op, input logic [CNT_W-1:0] cnt,
				input logic [VEC_W-1:0] start);
			int       span;
			int       limit;
			int       pos;
			int       i;
			bit       fits;
			outcome_t res;
			span = 1;
			while (span < int'(cnt)) span = span << 1;
			res.status = ST_OK;
			res.grant  = start;
			if (op == OP_FREE) begin
				// bits past the end of storage are dropped
				for (i = 0; i < span; i++) begin
					if (int'(start) + i < NUM_VECTORS) in_use[int'(start) + i] = 1'b0;
				end
			end else begin
				limit = (int'(vector_count) < NUM_VECTORS) ? int'(vector_count) : NUM_VECTORS;
				res.status = ST_FULL;
				res.grant  = '0;
				for (pos = 0; pos + span <= limit && res.status == ST_FULL; pos += span) begin
					fits = 1'b1;
					for (i = 0; i < span; i++) begin
						if (in_use[pos + i]) fits = 1'b0;
					end
					if (fits) begin
						for (i = 0; i < span; i++) in_use[pos + i] = 1'b1;
						res.status = ST_OK;
						res.grant  = VEC_W'(pos);
					end
				end
			end
			grants_due.push_back(res);
			return res;
		endfunction

		function void check_grant(input logic status, input logic [VEC_W-1:0] grant);
			outcome_t want;
			if (grants_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result: status %0d grant %0d", status, grant);
				return;
			end
			want = grants_due.pop_front();
			if (status !== want.status || grant !== want.grant) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("mismatch: expected status %0d grant %0d, got status %0d grant %0d",
						want.status, want.grant, status, grant);
			end
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;   // region_count [9:0], start_vector [18:10], zero pad
	logic [0:0]  s_tuser   = '0;   // opcode [0]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;          // granted_vector [8:0], zero pad
	logic [0:0]  m_tuser;          // status [0]
	logic        cfg_we    = 1'b0;
	logic [9:0]  cfg_wdata = '0;

	vector_bitmap_board board;
	int   results_seen = 0;
	int   requests_sent = 0;
	int   cycle_count = 0;
	logic sink_hold = 1'b0;

	// regions believed to be held, used to build well-formed free requests
	int live_start[$];
	int live_count[$];

	msi_vector_region_allocator_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			board.check_grant(m_tuser[0], m_tdata[VEC_W-1:0]);
			results_seen <= results_seen + 1;
		end
	end

	// receiver: random stalls, a quiet stretch, and the long hold-off
	always @(posedge clk) begin
		if (!arst_n || sink_hold) begin
			m_tready <= 1'b0;
		end else if (results_seen >= 600 && results_seen < 760) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// long receiver hold-off so the output register fills and the input stalls
	initial begin
		wait (results_seen >= 250);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_hold <= 1'b0;
	end

	// offer one request, wait for the handshake, then book it
	task automatic send_request(input logic op, input logic [CNT_W-1:0] cnt,
			input logic [VEC_W-1:0] start, output outcome_t res);
		while (!(requests_sent >= 400 && requests_sent < 550) &&
				$urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, start, cnt};
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		requests_sent++;
		res = board.book_request(op, cnt, start);
	endtask

	// wait for the block to go idle, then write vector_count
	task automatic set_vector_count(input logic [CNT_W-1:0] value);
		s_tvalid <= 1'b0;
		while (board.grants_due.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.vector_count = value;
	endtask

	// mostly allocate / free pairs over live regions, with some stray frees
	task automatic random_request();
		int               r;
		int               k;
		logic [CNT_W-1:0] cnt;
		outcome_t         res;
		r = $urandom_range(99);
		if (live_start.size() == 0 || r < ((live_start.size() < 6) ? 75 : 40)) begin
			r = $urandom_range(99);
			if (r < 50)      cnt = CNT_W'($urandom_range(1, 8));
			else if (r < 80) cnt = CNT_W'($urandom_range(9, 40));
			else if (r < 95) cnt = CNT_W'($urandom_range(41, 130));
			else             cnt = CNT_W'($urandom_range(0, 1023));
			send_request(OP_ALLOC, cnt, VEC_W'($urandom_range(0, 511)), res);
			if (res.status == ST_OK) begin
				live_start.push_back(int'(res.grant));
				live_count.push_back(int'(cnt));
			end
		end else if ($urandom_range(99) < 85) begin
			k = $urandom_range(live_start.size() - 1);
			send_request(OP_FREE, CNT_W'(live_count[k]), VEC_W'(live_start[k]), res);
			live_start.delete(k);
			live_count.delete(k);
		end else begin
			// stray free at a random spot, may hit live or free vectors
			if ($urandom_range(99) < 70) cnt = CNT_W'($urandom_range(0, 16));
			else                         cnt = CNT_W'($urandom_range(0, 1023));
			send_request(OP_FREE, cnt, VEC_W'($urandom_range(0, 511)), res);
		end
	endtask

	task automatic random_phase(input logic [CNT_W-1:0] value, input int count);
		set_vector_count(value);
		repeat (count) random_request();
	endtask

	initial begin
		outcome_t res;
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, full bound
		set_vector_count(10'd512);
		send_request(OP_ALLOC, 10'd0,    9'd0,   res);   // zero count means one vector
		send_request(OP_ALLOC, 10'd1,    9'd511, res);
		send_request(OP_ALLOC, 10'd2,    9'd0,   res);
		send_request(OP_ALLOC, 10'd3,    9'd0,   res);   // rounds up to four
		send_request(OP_ALLOC, 10'd512,  9'd0,   res);   // whole map, taken already
		send_request(OP_ALLOC, 10'd1023, 9'd0,   res);   // larger than the bound
		send_request(OP_FREE,  10'd8,    9'd0,   res);
		send_request(OP_FREE,  10'd8,    9'd0,   res);   // already free
		send_request(OP_ALLOC, 10'd512,  9'd0,   res);
		send_request(OP_ALLOC, 10'd1,    9'd0,   res);   // map full
		send_request(OP_FREE,  10'd1023, 9'd511, res);   // runs past the end of storage
		send_request(OP_ALLOC, 10'd1,    9'd0,   res);
		send_request(OP_FREE,  10'd512,  9'd0,   res);
		send_request(OP_ALLOC, 10'd33,   9'd0,   res);
		send_request(OP_ALLOC, 10'd32,   9'd0,   res);
		send_request(OP_ALLOC, 10'd17,   9'd0,   res);
		send_request(OP_ALLOC, 10'd256,  9'd0,   res);
		send_request(OP_FREE,  10'd682,  9'd341, res);
		send_request(OP_FREE,  10'd341,  9'd170, res);

		// zero bound: no allocate can fit
		set_vector_count(10'd0);
		send_request(OP_ALLOC, 10'd1,    9'd0,   res);
		send_request(OP_FREE,  10'd64,   9'd0,   res);

		// single vector bound
		set_vector_count(10'd1);
		send_request(OP_ALLOC, 10'd1,    9'd0,   res);
		send_request(OP_ALLOC, 10'd2,    9'd0,   res);
		send_request(OP_FREE,  10'd1,    9'd0,   res);

		// bound above storage is clamped to the map size
		set_vector_count(10'd1023);
		send_request(OP_ALLOC, 10'd512,  9'd0,   res);
		send_request(OP_FREE,  10'd512,  9'd0,   res);

		// random part over several bounds
		random_phase(10'd512,  180);
		random_phase(10'd1023, 180);
		random_phase(10'd300,  180);
		random_phase(10'd1,    40);
		random_phase(10'd0,    40);
		random_phase(10'd100,  180);
		random_phase(CNT_W'($urandom_range(1, 512)), 180);

		// drain and let the block settle
		s_tvalid <= 1'b0;
		while (board.grants_due.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (board.mismatches == 0 && board.grants_due.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
